// ===== hw/rtl/tspwp_pkg.sv =====
// ----------------------------------------------------------------------------
// tspwp_pkg
// Shared types and constants of the window-permutation tour improver.
// ----------------------------------------------------------------------------
`default_nettype none

package tspwp_pkg;

    localparam int CITY_W  = 6;
    localparam int COST_W  = 16;
    localparam int NUMC_W  = 7;
    localparam int WINDOW  = 5;
    localparam int EMIT_CAP = 64;

    typedef enum logic [1:0] {
        MODE_COST = 2'd0,
        MODE_TOUR = 2'd1,
        MODE_RUN  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]        mode;
        logic [CITY_W-1:0] from_city;
        logic [CITY_W-1:0] to_city;
        logic [COST_W-1:0] edge_cost;
        logic [CITY_W-1:0] position;
        logic [CITY_W-1:0] city;
    } t_in_item;

    typedef struct packed {
        logic [CITY_W-1:0] tour_position;
        logic [CITY_W-1:0] tour_city;
        logic              last;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hw/rtl/tspwp_ram.sv =====
// ----------------------------------------------------------------------------
// tspwp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tspwp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tsp_window_permutation_improver.sv =====
// ----------------------------------------------------------------------------
// tsp_window_permutation_improver
// Window-permutation local search over an asymmetric tour.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_in): mode 0 writes one
//   cost entry, mode 1 writes one tour slot, mode 3 is dropped; loads are
//   accepted back to back while the block is idle.
//   Mode 2 runs the search and then emits the tour, one request per slot on
//   the output channel (o_out_valid / i_out_stall, payload o_out), slot 0
//   first, last set on the final slot. o_in_stall stays high from the run
//   request until the last slot has been taken.
//   Each window reads its five tour slots through the registered read port,
//   then its twelve cost entries, then picks the move; a winning move writes
//   back the three reordered middle slots. After the search the slots go out
//   one at a time: valid drops when a slot is taken, and the next slot is
//   presented only after that, while the receiver does not stall.
//   The config port (i_cfg_valid / o_cfg_ready, i_cfg_data) sets num_cities;
//   it is always ready and the value is taken when a run starts.
//   Reset returns to idle with no output pending and num_cities 5; the
//   memories keep undefined contents until written. While the receiver
//   stalls, the output request holds and the block waits.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_window_permutation_improver #(
    parameter int MAX_CITIES = 64,
    parameter int COST_BITS  = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire tspwp_pkg::t_in_item    i_in,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output tspwp_pkg::t_out_item        o_out,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [tspwp_pkg::NUMC_W-1:0] i_cfg_data
);

    localparam int PW = $clog2(MAX_CITIES);
    localparam int AW = 2 * PW;
    localparam int SW = COST_BITS + 2;
    localparam int HI = (MAX_CITIES < tspwp_pkg::EMIT_CAP) ? MAX_CITIES
                                                           : tspwp_pkg::EMIT_CAP;
    localparam int CW = tspwp_pkg::CITY_W;
    localparam int NW = tspwp_pkg::NUMC_W;

    typedef enum logic [2:0] {
        S_IDLE, S_TREAD, S_CREAD, S_EVAL, S_WRITE, S_EREAD, S_ELOAD, S_EOUT
    } t_state;

    t_state r_state;
    logic [NW-1:0] r_numc;
    logic [NW-1:0] r_n, r_ws, r_idle, r_k;
    logic [3:0] r_step;
    logic [CW-1:0] r_c [5];
    logic [SW-1:0] r_base;
    logic [SW-1:0] r_alt [4];
    logic [1:0] r_pick;
    logic [1:0] r_wcnt;

    // tour memory ports
    logic tr_we;
    logic [PW-1:0] tr_waddr, tr_raddr;
    logic [CW-1:0] tr_wdata, tr_rdata;
    // cost memory ports
    logic cs_we;
    logic [AW-1:0] cs_waddr, cs_raddr;
    logic [COST_BITS-1:0] cs_wdata, cs_rdata;

    tspwp_ram #(.WIDTH(CW), .DEPTH(MAX_CITIES)) u_tour (
        .i_clk(i_clk), .i_we(tr_we), .i_waddr(tr_waddr), .i_wdata(tr_wdata),
        .i_raddr(tr_raddr), .o_rdata(tr_rdata));
    tspwp_ram #(.WIDTH(COST_BITS), .DEPTH(1 << AW)) u_cost (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(cs_waddr), .i_wdata(cs_wdata),
        .i_raddr(cs_raddr), .o_rdata(cs_rdata));

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);

    logic in_acc;
    assign in_acc = i_in_valid && (r_state == S_IDLE);

    // window slot of offset j, with wraparound
    function automatic logic [6:0] slot(input logic [6:0] ws, input logic [6:0] j,
                                        input logic [6:0] n);
        logic [7:0] s;
        s = {1'b0, ws} + {1'b0, j};
        if (s >= {1'b0, n}) s = s - {1'b0, n};
        return s[6:0];
    endfunction

    // cost read order: base ab bc cd de, then ac cb bd be ad dc ce db
    logic [2:0] rf, rt;
    always_comb begin
        rf = 3'd0; rt = 3'd1;
        case (r_step)
            4'd0:  begin rf = 3'd0; rt = 3'd1; end
            4'd1:  begin rf = 3'd1; rt = 3'd2; end
            4'd2:  begin rf = 3'd2; rt = 3'd3; end
            4'd3:  begin rf = 3'd3; rt = 3'd4; end
            4'd4:  begin rf = 3'd0; rt = 3'd2; end
            4'd5:  begin rf = 3'd2; rt = 3'd1; end
            4'd6:  begin rf = 3'd1; rt = 3'd3; end
            4'd7:  begin rf = 3'd1; rt = 3'd4; end
            4'd8:  begin rf = 3'd0; rt = 3'd3; end
            4'd9:  begin rf = 3'd3; rt = 3'd2; end
            4'd10: begin rf = 3'd2; rt = 3'd4; end
            4'd11: begin rf = 3'd3; rt = 3'd1; end
            default: begin rf = 3'd0; rt = 3'd1; end
        endcase
    end

    // which sums take the arriving cost: bit 0 base, bits 1..4 the reorderings
    logic [3:0] di;
    logic [4:0] add_mask;
    assign di = r_step - 4'd1;
    always_comb begin
        case (di)
            4'd0:    add_mask = 5'b00001;
            4'd1:    add_mask = 5'b10001;
            4'd2:    add_mask = 5'b00101;
            4'd3:    add_mask = 5'b00011;
            4'd4:    add_mask = 5'b00110;
            4'd5:    add_mask = 5'b01010;
            4'd6:    add_mask = 5'b00010;
            4'd7:    add_mask = 5'b01100;
            4'd8:    add_mask = 5'b11000;
            4'd9:    add_mask = 5'b01000;
            4'd10:   add_mask = 5'b10000;
            4'd11:   add_mask = 5'b10100;
            default: add_mask = 5'b00000;
        endcase
    end

    logic [CW-1:0] fcity, tcity;
    assign fcity = r_c[rf];
    assign tcity = r_c[rt];

    // memory port control
    logic [NW-1:0] wslot;
    always_comb begin
        wslot    = slot(r_ws, NW'(r_wcnt) + NW'(1), r_n);
        tr_we    = 1'b0;
        tr_waddr = PW'(i_in.position);
        tr_wdata = i_in.city;
        cs_we    = 1'b0;
        cs_waddr = {PW'(i_in.from_city), PW'(i_in.to_city)};
        cs_wdata = COST_BITS'(i_in.edge_cost);
        cs_raddr = {PW'(fcity), PW'(tcity)};
        tr_raddr = PW'(r_k);
        if (in_acc && i_in.mode == tspwp_pkg::MODE_COST
                && int'(i_in.from_city) < MAX_CITIES && int'(i_in.to_city) < MAX_CITIES) begin
            cs_we = 1'b1;
        end
        if (in_acc && i_in.mode == tspwp_pkg::MODE_TOUR
                && int'(i_in.position) < MAX_CITIES && int'(i_in.city) < MAX_CITIES) begin
            tr_we = 1'b1;
        end
        if (r_state == S_TREAD) begin
            tr_raddr = PW'(slot(r_ws, NW'(r_step), r_n));
        end
        // next slot is fetched while the current one waits for the receiver
        if (r_state == S_EOUT) begin
            tr_raddr = PW'(r_k + NW'(1));
        end
        if (r_state == S_WRITE) begin
            tr_we    = 1'b1;
            tr_waddr = PW'(wslot);
            case (r_pick)
                2'd0:    tr_wdata = (r_wcnt == 2'd0) ? r_c[2] :
                                    (r_wcnt == 2'd1) ? r_c[1] : r_c[3];
                2'd1:    tr_wdata = (r_wcnt == 2'd0) ? r_c[2] :
                                    (r_wcnt == 2'd1) ? r_c[3] : r_c[1];
                2'd2:    tr_wdata = (r_wcnt == 2'd0) ? r_c[3] :
                                    (r_wcnt == 2'd1) ? r_c[2] : r_c[1];
                default: tr_wdata = (r_wcnt == 2'd0) ? r_c[3] :
                                    (r_wcnt == 2'd1) ? r_c[1] : r_c[2];
            endcase
        end
    end

    // evaluation of savings, first strictly largest
    logic [SW-1:0] sv [4];
    logic [SW-1:0] best;
    logic          found;
    logic [1:0]    pick;
    always_comb begin
        best = '0; found = 1'b0; pick = 2'd0;
        for (int k = 0; k < 4; k++) begin
            sv[k] = r_base - r_alt[k];
            if (r_base > r_alt[k] && sv[k] > best) begin
                best = sv[k]; found = 1'b1; pick = 2'(k);
            end
        end
    end

    logic [NW-1:0] n_n;
    always_comb begin
        n_n = r_numc;
        if (r_numc < NW'(tspwp_pkg::WINDOW)) n_n = NW'(tspwp_pkg::WINDOW);
        if (r_numc > NW'(HI)) n_n = NW'(HI);
    end

    logic [NW-1:0] ws_next;
    assign ws_next = (r_ws + NW'(1) == r_n) ? '0 : r_ws + NW'(1);

    logic [SW-1:0] cext;
    assign cext = SW'(cs_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_numc      <= NW'(tspwp_pkg::WINDOW);
            r_ws        <= '0;
            r_idle      <= '0;
            o_out_valid <= 1'b0;
            o_out       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_numc <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.mode == tspwp_pkg::MODE_RUN) begin
                        r_n     <= n_n;
                        r_ws    <= '0;
                        r_idle  <= '0;
                        r_step  <= '0;
                        r_state <= S_TREAD;
                    end
                end
                S_TREAD: begin
                    // read data arrives in the cycle after its address
                    if (r_step != 4'd0) r_c[3'(r_step - 4'd1)] <= tr_rdata;
                    if (r_step == 4'd5) begin
                        r_step  <= '0;
                        r_base  <= '0;
                        for (int k = 0; k < 4; k++) r_alt[k] <= '0;
                        r_state <= S_CREAD;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_CREAD: begin
                    if (r_step != 4'd0) begin
                        if (add_mask[0]) r_base <= r_base + cext;
                        for (int k = 0; k < 4; k++) begin
                            if (add_mask[k+1]) r_alt[k] <= r_alt[k] + cext;
                        end
                    end
                    if (r_step == 4'd12) begin
                        r_step  <= '0;
                        r_state <= S_EVAL;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_EVAL: begin
                    if (found) begin
                        r_pick  <= pick;
                        r_wcnt  <= '0;
                        r_idle  <= '0;
                        r_state <= S_WRITE;
                    end else begin
                        r_ws   <= ws_next;
                        r_idle <= r_idle + NW'(1);
                        if (r_idle + NW'(1) >= r_n) begin
                            r_k     <= '0;
                            r_state <= S_EREAD;
                        end else begin
                            r_state <= S_TREAD;
                        end
                    end
                end
                S_WRITE: begin
                    if (r_wcnt == 2'd2) begin
                        r_ws    <= ws_next;
                        r_state <= S_TREAD;
                    end else begin
                        r_wcnt <= r_wcnt + 2'd1;
                    end
                end
                S_EREAD: begin
                    r_state <= S_ELOAD;
                end
                S_ELOAD: begin
                    o_out.tour_position <= CW'(r_k);
                    o_out.tour_city     <= tr_rdata;
                    o_out.last          <= (r_k + NW'(1) == r_n);
                    o_out_valid         <= 1'b1;
                    r_state             <= S_EOUT;
                end
                S_EOUT: begin
                    if (!i_out_stall) begin
                        o_out_valid <= 1'b0;
                        if (o_out.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + NW'(1);
                            r_state <= S_ELOAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
